>>> rtl/gripper_pick_place_sequencer_assert.svh
// Assertion macros used by the gripper sequencer port checker.
`ifndef GRIPPER_PICK_PLACE_SEQUENCER_ASSERT_SVH
`define GRIPPER_PICK_PLACE_SEQUENCER_ASSERT_SVH

// Clocked assertion, held off while reset is high.
`define GPPS_ASSERT_RST(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define GPPS_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

>>> rtl/gpps_pkg.sv
// Types and constants for the gripper pick and place sequencer.
package gpps_pkg;

  localparam int TIMEOUT_BITS = 16;
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 16'd3000;

  // Command codes carried by each tick word
  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_UP     = 3'd1,
    CMD_DOWN   = 3'd2,
    CMD_OPEN   = 3'd3,
    CMD_CLOSE  = 3'd4,
    CMD_TOGGLE = 3'd5,
    CMD_PICK   = 3'd6,
    CMD_PLACE  = 3'd7
  } cmd_t;

  // How a step ended
  typedef enum logic [1:0] {
    END_NONE    = 2'd0,
    END_REACHED = 2'd1,
    END_TIMEOUT = 2'd2
  } step_end_t;

  // Relay action of one sequence step
  typedef enum logic [1:0] {
    ACT_OPEN  = 2'd0,
    ACT_DOWN  = 2'd1,
    ACT_CLOSE = 2'd2,
    ACT_UP    = 2'd3
  } act_t;

  localparam logic [1:0] LAST_STEP = 2'd3;

  // Pick: open, down, close, up. Place: down, open, up, close.
  function automatic act_t step_action(input logic is_place, input logic [1:0] step);
    act_t act;
    unique case (step)
      2'd0:    act = is_place ? ACT_DOWN  : ACT_OPEN;
      2'd1:    act = is_place ? ACT_OPEN  : ACT_DOWN;
      2'd2:    act = is_place ? ACT_UP    : ACT_CLOSE;
      default: act = is_place ? ACT_CLOSE : ACT_UP;
    endcase
    return act;
  endfunction

endpackage

>>> rtl/gripper_pick_place_sequencer.sv
// Gripper pick and place sequencer: tick input register, step logic, result register.
//
//   channel | handshake              | word
//   --------+------------------------+------------------------------------------------
//   in      | in_valid / in_stall    | cmd, reed_open, reed_down, reed_close, reed_up
//   out     | out_valid / out_stall  | relays, busy_res, step_end, step_index, done
//   cfg     | cfg_valid / cfg_ready  | cfg_timeout_ticks
//
// One tick word per cycle while out_stall lets the result register drain; a word is
// held in the input register after acceptance, then passes once through the step logic
// into the result register.
// The result register and the input register each hold one word, so a new tick is
// taken while a finished result waits; in_stall rises only when both are full.
// Synchronous reset: relay state off, toggle flag open, sequencer idle, timeout 3000.
module gripper_pick_place_sequencer #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic        reed_open,
  input  logic        reed_down,
  input  logic        reed_close,
  input  logic        reed_up,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        arm_up_relay,
  output logic        claw_close_relay,
  output logic        busy_res,
  output logic [1:0]  step_end,
  output logic [1:0]  step_index,
  output logic        sequence_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_timeout_ticks
);
  import gpps_pkg::*;

  localparam int CMP_BITS = (COUNT_BITS > TIMEOUT_BITS) ? COUNT_BITS : TIMEOUT_BITS;

  // Input register
  logic       in_full;
  cmd_t       in_cmd;
  logic       tick_open, tick_down, tick_close, tick_up;

  // Sequencer state
  logic [TIMEOUT_BITS-1:0] timeout_ticks;
  logic                    arm_up_out, claw_close_out, toggle_says_open;
  logic                    running, sequence_is_place;
  logic [1:0]              current_step;
  logic [COUNT_BITS-1:0]   elapsed_ticks;

  logic                    arm_next, claw_next, toggle_next, running_next, place_next;
  logic [1:0]              step_next;
  logic [COUNT_BITS-1:0]   elapsed_next;
  step_end_t               end_next;
  logic [1:0]              index_next;
  logic                    done_next;

  logic                    advance;
  act_t                    act;
  logic                    reed_hit;
  logic [CMP_BITS-1:0]     elapsed_wide, timeout_wide;

  // Move the held word into the result register when that slot is free
  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;
  assign cfg_ready = 1'b1;

  // Capture the tick word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_cmd     <= cmd_t'(cmd);
      tick_open  <= reed_open;
      tick_down  <= reed_down;
      tick_close <= reed_close;
      tick_up    <= reed_up;
    end
  end

  assign elapsed_wide = CMP_BITS'(elapsed_ticks);
  assign timeout_wide = CMP_BITS'(timeout_ticks);

  // Step logic: idle commands, then the active step
  always_comb begin
    arm_next     = arm_up_out;
    claw_next    = claw_close_out;
    toggle_next  = toggle_says_open;
    running_next = running;
    place_next   = sequence_is_place;
    step_next    = current_step;
    elapsed_next = elapsed_ticks;
    end_next     = END_NONE;
    index_next   = 2'd0;
    done_next    = 1'b0;
    act          = ACT_OPEN;
    reed_hit     = 1'b0;

    if (!running) begin
      unique case (in_cmd)
        CMD_NONE:   ;
        CMD_UP:     arm_next = 1'b1;
        CMD_DOWN:   arm_next = 1'b0;
        CMD_OPEN:   claw_next = 1'b0;
        CMD_CLOSE:  claw_next = 1'b1;
        CMD_TOGGLE: begin
          claw_next   = toggle_says_open;
          toggle_next = !toggle_says_open;
        end
        CMD_PICK, CMD_PLACE: begin
          running_next = 1'b1;
          place_next   = (in_cmd == CMD_PLACE);
          step_next    = 2'd0;
          elapsed_next = '0;
        end
      endcase
    end

    if (running_next) begin
      act = step_action(place_next, step_next);
      unique case (act)
        ACT_OPEN: begin
          claw_next = 1'b0;
          reed_hit  = tick_open;
        end
        ACT_DOWN: begin
          arm_next = 1'b0;
          reed_hit = tick_down;
        end
        ACT_CLOSE: begin
          claw_next = 1'b1;
          reed_hit  = tick_close;
        end
        ACT_UP: begin
          arm_next = 1'b1;
          reed_hit = tick_up;
        end
      endcase

      // Reed wins over timeout; a saturated count also times out
      if (reed_hit) begin
        end_next = END_REACHED;
      end else if (running && (elapsed_wide >= timeout_wide || &elapsed_ticks)) begin
        end_next = END_TIMEOUT;
      end else if (!running && timeout_wide == '0) begin
        end_next = END_TIMEOUT;
      end else begin
        elapsed_next = elapsed_next + COUNT_BITS'(1);
      end

      if (end_next != END_NONE) begin
        index_next   = step_next;
        elapsed_next = '0;
        if (step_next == LAST_STEP) begin
          running_next = 1'b0;
          step_next    = 2'd0;
          done_next    = 1'b1;
        end else begin
          step_next = step_next + 2'd1;
        end
      end
    end
  end

  // Update state and load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks     <= TIMEOUT_RESET;
      arm_up_out        <= 1'b0;
      claw_close_out    <= 1'b0;
      toggle_says_open  <= 1'b1;
      running           <= 1'b0;
      sequence_is_place <= 1'b0;
      current_step      <= 2'd0;
      elapsed_ticks     <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout_ticks <= cfg_timeout_ticks;
      end
      if (advance) begin
        arm_up_out        <= arm_next;
        claw_close_out    <= claw_next;
        toggle_says_open  <= toggle_next;
        running           <= running_next;
        sequence_is_place <= place_next;
        current_step      <= step_next;
        elapsed_ticks     <= elapsed_next;
        out_valid         <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      arm_up_relay     <= arm_next;
      claw_close_relay <= claw_next;
      busy_res         <= running_next;
      step_end         <= end_next;
      step_index       <= index_next;
      sequence_done    <= done_next;
    end
  end

endmodule

>>> rtl/gpps_checker.sv
// Port-level checker for the gripper sequencer, with its bind.
`include "gripper_pick_place_sequencer_assert.svh"

module gpps_port_assertions (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       arm_up_relay,
  input logic       claw_close_relay,
  input logic       busy_res,
  input logic [1:0] step_end,
  input logic [1:0] step_index,
  input logic       sequence_done
);
  import gpps_pkg::*;

  // Done only on the last step, which ends the sequence
  `GPPS_ASSERT_RST(a_done_last, clk, rst, out_valid && sequence_done |-> !busy_res && step_index == LAST_STEP && step_end != END_NONE, "sequence_done outside last step end")

  // A word with no step end reports no step
  `GPPS_ASSERT_RST(a_no_end_quiet, clk, rst, out_valid && step_end == END_NONE |-> step_index == 2'd0 && !sequence_done, "step index or done without a step end")

  // The last step ending always closes the sequence
  `GPPS_ASSERT_RST(a_last_closes, clk, rst, out_valid && step_end != END_NONE && step_index == LAST_STEP |-> sequence_done, "last step ended without sequence_done")

  // A stalled result word holds
  `GPPS_ASSERT_RST(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(arm_up_relay) && $stable(claw_close_relay) && $stable(busy_res) && $stable(step_end) && $stable(step_index) && $stable(sequence_done), "stalled result word changed")

endmodule

bind gripper_pick_place_sequencer gpps_port_assertions u_gpps_port_assertions (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .arm_up_relay     (arm_up_relay),
  .claw_close_relay (claw_close_relay),
  .busy_res         (busy_res),
  .step_end         (step_end),
  .step_index       (step_index),
  .sequence_done    (sequence_done)
);
